>>> rtl/aufifo_pkg.sv
`default_nettype none

package aufifo_pkg;

    // Store geometry and discard threshold
    localparam int STORE_DEPTH = 8192;
    localparam int DROP_LIMIT  = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int FILL_W   = 14;
    localparam int CMD_W    = 2;

    // Q1.15 unity gain
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(32768);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_VOLUME_GAIN   = 1'b0;
    localparam logic CFG_OUTPUT_STEREO = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       source_mono;
        logic                       block_start;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       underrun;
        logic                       overflow;
        logic [FILL_W-1:0]          fill_count;
    } t_out_word;

endpackage

`default_nettype wire

>>> rtl/aufifo_ram.sv
`default_nettype none

module aufifo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port: write, or register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> rtl/audio_upmix_fifo_with_gain_unit.sv
// Steps from input accept to output valid: clear, no-op and underrun go straight to hand-off,
// push writes one entry (two when a mono sample is doubled), pop does memory read, multiply, round.
// One word is in work at a time; the next is accepted the cycle after the result moves to
// the output register, and that hand-off waits while the held output word is not taken.
// Reset (synchronous, active low) empties the store, sets gain to 1.0 and stereo output;
// store contents are not cleared.
`default_nettype none

module audio_upmix_fifo_with_gain_unit
    import aufifo_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_word          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_word              o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [GAIN_W-1:0] i_cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_WR2  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

    // Add with wrap at the store depth; a stays below the depth and b does not exceed it
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(STORE_DEPTH)) begin
            s = s - (CNT_W+1)'(STORE_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    logic [2:0]                 r_state, n_state;
    logic [ADDR_W-1:0]          r_head, n_head;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [GAIN_W-1:0]          r_gain;
    logic                       r_stereo;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic                       r_need2, n_need2;
    t_out_word                  r_res, n_res;
    t_out_word                  r_out, n_out;
    logic                       r_out_valid, n_out_valid;
    logic signed [PROD_W-1:0]   r_prod, n_prod;

    logic                       in_acc;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_addr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic [GAIN_W-1:0]          gain_clamped;
    logic [CNT_W-1:0]           half;
    logic [CNT_W:0]             fill_after;
    logic signed [PROD_W-1:0]   prod_round;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;
    assign gain_clamped = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
    assign half         = r_count >> 1;
    assign prod_round   = (r_prod + PROD_W'(16384)) >>> 15;

    aufifo_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_sample),
        .o_rdata(ram_rdata)
    );

    // Sequence one word: discard, writes, read and scale, hand off
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_sample    = r_sample;
        n_need2     = r_need2;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_prod      = r_prod;
        ram_we      = 1'b0;
        ram_addr    = ring_add(r_head, r_count);
        fill_after  = (CNT_W+1)'(r_count) + (CNT_W+1)'(r_need2 ? 2 : 1);

        // Drop the output word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    unique case (i_in_data.cmd)
                        CMD_PUSH: begin
                            n_sample = i_in_data.sample_in;
                            n_need2  = i_in_data.source_mono && r_stereo;
                            // Discard the oldest half on a block start once the fill reaches DROP_LIMIT
                            if (i_in_data.block_start && (32'(r_count) >= DROP_LIMIT)) begin
                                n_head           = ring_add(r_head, half);
                                n_count          = r_count - half;
                                n_res.overflow   = 1'b1;
                            end
                            n_state = ST_PUSH;
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_res.underrun = 1'b1;
                                n_state        = ST_DONE;
                            end else begin
                                ram_addr = r_head;
                                n_head   = ring_add(r_head, CNT_W'(1));
                                n_count  = r_count - CNT_W'(1);
                                n_state  = ST_RD;
                            end
                        end
                        CMD_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                            n_state = ST_DONE;
                        end
                        CMD_NOP: begin
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PUSH: begin
                // Drop the whole push without room for all its entries
                if (fill_after > (CNT_W+1)'(STORE_DEPTH)) begin
                    n_res.overflow = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = r_need2 ? ST_WR2 : ST_DONE;
                end
            end
            ST_WR2: begin
                ram_we  = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = ST_DONE;
            end
            ST_RD: begin
                n_prod  = PROD_W'($signed(ram_rdata)) * $signed({1'b0, gain_clamped});
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_res.sample_out = prod_round[SAMPLE_W-1:0];
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                // Hand off when the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out            = r_res;
                    n_out.fill_count = FILL_W'(r_count);
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_gain      <= GAIN_ONE;
            r_stereo    <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VOLUME_GAIN:   r_gain   <= i_cfg_wdata;
                    CFG_OUTPUT_STEREO: r_stereo <= i_cfg_wdata[0];
                    default:           r_gain   <= r_gain;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_need2  <= n_need2;
        r_res    <= n_res;
        r_out    <= n_out;
        r_prod   <= n_prod;
    end

endmodule

`default_nettype wire

>>> verif/audio_upmix_fifo_with_gain_unit_test.sv
`timescale 1ns / 100ps

module audio_upmix_fifo_with_gain_unit_test;
    import aufifo_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SET_COUNT   = 6;
    localparam int SET_WORDS   = 156;
    localparam int FILL_WORDS  = 64;
    localparam int DRAIN_WORDS = 130;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES = 8;

    // Tracks ring contents, head and fill; predicts each output word
    class ring_fifo_tracker;
        logic [SAMPLE_W-1:0] ring [STORE_DEPTH];
        int unsigned         head_idx;
        int unsigned         fill;
        logic [GAIN_W-1:0]   gain;
        bit                  stereo;
        t_out_word           outputs_due[$];
        int unsigned         mismatches;

        function new();
            head_idx   = 0;
            fill       = 0;
            gain       = GAIN_ONE;
            stereo     = 1'b1;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [GAIN_W-1:0] val);
            if (idx == CFG_VOLUME_GAIN)
                gain = val;
            else
                stereo = val[0];
        endfunction

        // Q1.15 multiply, round half up, gain clamped to unity
        function logic [SAMPLE_W-1:0] apply_volume(logic [SAMPLE_W-1:0] raw);
            logic [GAIN_W-1:0] g;
            logic signed [33:0] prod;
            logic signed [33:0] rounded;
            g = (gain > GAIN_ONE) ? GAIN_ONE : gain;
            prod = $signed(raw) * $signed({1'b0, g});
            rounded = (prod + 34'sd16384) >>> 15;
            return rounded[SAMPLE_W-1:0];
        endfunction

        function void accept_word(t_in_word w);
            t_out_word   r;
            int unsigned need;
            int unsigned half;
            int unsigned k;
            r = '0;
            case (w.cmd)
                CMD_PUSH: begin
                    need = (w.source_mono && stereo) ? 2 : 1;
                    // discard the oldest half when a block starts too full
                    if (w.block_start && fill >= DROP_LIMIT) begin
                        half       = fill / 2;
                        head_idx   = (head_idx + half) % STORE_DEPTH;
                        fill       = fill - half;
                        r.overflow = 1'b1;
                    end
                    // drop the whole push unless every entry fits
                    if (fill + need > STORE_DEPTH) begin
                        r.overflow = 1'b1;
                    end else begin
                        for (k = 0; k < need; k++) begin
                            ring[(head_idx + fill) % STORE_DEPTH] = w.sample_in;
                            fill++;
                        end
                    end
                end
                CMD_POP: begin
                    if (fill == 0) begin
                        r.underrun = 1'b1;
                    end else begin
                        r.sample_out = apply_volume(ring[head_idx]);
                        head_idx     = (head_idx + 1) % STORE_DEPTH;
                        fill--;
                    end
                end
                CMD_CLEAR: begin
                    head_idx = 0;
                    fill     = 0;
                end
                default: ;
            endcase
            r.fill_count = FILL_W'(fill);
            outputs_due.push_back(r);
        endfunction

        function void check_word(t_out_word got);
            t_out_word exp;
            if (outputs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: out=%0d und=%0b ovf=%0b fill=%0d",
                             got.sample_out, got.underrun, got.overflow, got.fill_count);
                return;
            end
            exp = outputs_due.pop_front();
            if (got.sample_out !== exp.sample_out || got.underrun !== exp.underrun ||
                got.overflow !== exp.overflow || got.fill_count !== exp.fill_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp out=%0d und=%0b ovf=%0b fill=%0d",
                             exp.sample_out, exp.underrun, exp.overflow, exp.fill_count,
                             ", got out=%0d und=%0b ovf=%0b fill=%0d",
                             got.sample_out, got.underrun, got.overflow, got.fill_count);
            end
        endfunction

        function int pending();
            return outputs_due.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_word          in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_word         out_data;
    logic              cfg_we = 1'b0;
    logic              cfg_index = CFG_VOLUME_GAIN;
    logic [GAIN_W-1:0] cfg_wdata = '0;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          rx_hold_start = 1'b0;
    int          hold_left = 0;
    int unsigned cycle_count = 0;

    ring_fifo_tracker tracker = new();

    audio_upmix_fifo_with_gain_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Drive the reader: long hold-off on request, random stalls otherwise
    always @(posedge clk) begin
        if (rx_hold_start) begin
            rx_hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Record each accepted word on both sides
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                tracker.accept_word(in_data);
            if (out_valid === 1'b1 && out_ready)
                tracker.check_word(out_data);
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic t_in_word compose_word(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp,
                                              bit mono, bit bstart);
        t_in_word w;
        w.cmd         = cmd;
        w.sample_in   = smp;
        w.source_mono = mono;
        w.block_start = bstart;
        return w;
    endfunction

    function automatic t_in_word random_word();
        int               pick;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 44)
            cmd = CMD_PUSH;
        else if (pick < 84)
            cmd = CMD_POP;
        else if (pick < 92)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_NOP;
        return compose_word(cmd, pick_sample(), 1'($urandom_range(1)),
                            $urandom_range(5) == 0);
    endfunction

    // Offer one word after a random gap; hold it until accepted
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait for every pending output word
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [GAIN_W-1:0] gain, input bit stereo);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VOLUME_GAIN;
        cfg_wdata <= gain;
        @(posedge clk);
        tracker.set_register(CFG_VOLUME_GAIN, gain);
        cfg_index <= CFG_OUTPUT_STEREO;
        cfg_wdata <= GAIN_W'(stereo);
        @(posedge clk);
        tracker.set_register(CFG_OUTPUT_STEREO, GAIN_W'(stereo));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Push a run with the reader held off so the input stalls,
    // then pop until the store runs dry
    task automatic fill_and_drain();
        int i;
        send_word(compose_word(CMD_CLEAR, pick_sample(), 1'b0, 1'b0));
        rx_hold_start = 1'b1;
        for (i = 0; i < FILL_WORDS; i++)
            send_word(compose_word(CMD_PUSH, pick_sample(), 1'($urandom_range(1)),
                                   $urandom_range(7) == 0));
        for (i = 0; i < DRAIN_WORDS; i++)
            send_word(compose_word(CMD_POP, pick_sample(), 1'($urandom_range(1)),
                                   1'($urandom_range(1))));
    endtask

    task automatic random_words(input int count);
        int n;
        int k;
        int burst;
        n = 0;
        while (n < count) begin
            // now and then push a run so the fill climbs
            if ($urandom_range(11) == 0) begin
                burst = $urandom_range(40, 8);
                for (k = 0; k < burst; k++)
                    send_word(compose_word(CMD_PUSH, pick_sample(), 1'($urandom_range(1)),
                                           $urandom_range(7) == 0));
                n += burst;
            end else begin
                send_word(random_word());
                n++;
            end
        end
    endtask

    initial begin
        logic [GAIN_W-1:0] set_gain [SET_COUNT];
        bit                set_stereo [SET_COUNT];
        int                s;

        set_gain[0] = 16'hFFFF;  set_stereo[0] = 1'b1;
        set_gain[1] = 16'h4000;  set_stereo[1] = 1'b0;
        set_gain[2] = 16'h0000;  set_stereo[2] = 1'b1;
        set_gain[3] = 16'h0001;  set_stereo[3] = 1'b0;
        set_gain[4] = GAIN_W'($urandom_range(32768)); set_stereo[4] = 1'b0;
        set_gain[5] = GAIN_ONE;  set_stereo[5] = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset settings: unity gain, stereo output
        send_word(compose_word(CMD_POP,   16'h0000, 1'b0, 1'b0));
        send_word(compose_word(CMD_PUSH,  16'h7FFF, 1'b0, 1'b1));
        send_word(compose_word(CMD_PUSH,  16'h8000, 1'b1, 1'b0));
        send_word(compose_word(CMD_PUSH,  16'h0001, 1'b1, 1'b1));
        send_word(compose_word(CMD_PUSH,  16'hFFFF, 1'b0, 1'b0));
        send_word(compose_word(CMD_NOP,   16'hFFFF, 1'b1, 1'b1));
        repeat (6) send_word(compose_word(CMD_POP, 16'hA5A5, 1'b1, 1'b1));
        send_word(compose_word(CMD_POP,   16'h5A5A, 1'b0, 1'b0));
        send_word(compose_word(CMD_PUSH,  16'h1234, 1'b1, 1'b0));
        send_word(compose_word(CMD_PUSH,  16'hFEDC, 1'b0, 1'b1));
        send_word(compose_word(CMD_CLEAR, 16'hFFFF, 1'b1, 1'b1));
        send_word(compose_word(CMD_POP,   16'h0000, 1'b0, 1'b0));
        send_word(compose_word(CMD_NOP,   16'h0000, 1'b0, 1'b0));

        // Step through settings: receiver then sender mostly idle, then neither
        for (s = 0; s < SET_COUNT; s++) begin
            if (s < 2) begin
                tx_idle_pct = 36;
                rx_idle_pct = 76;
            end else if (s < 4) begin
                tx_idle_pct = 76;
                rx_idle_pct = 36;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            settle();
            apply_settings(set_gain[s], set_stereo[s]);
            if (s == 0)
                fill_and_drain();
            random_words(SET_WORDS);
        end

        settle();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
